// File: sv/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared sizes and types for the stream group reversal block.
// ----------------------------------------------------------------------------
package sgr_pkg;

	localparam int MAX_GROUP = 16;
	localparam int VALUE_W   = 32;
	localparam int GS_W      = 5;

	// Index of an entry inside one bank, and a count that can hold MAX_GROUP.
	localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CNT_W     = $clog2(MAX_GROUP + 1);

	// Two banks of MAX_GROUP entries each.
	localparam int RAM_DEPTH = 2 * (1 << IDX_W);
	localparam int ADDR_W    = IDX_W + 1;

	// One finished group handed from the front to the back.
	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic             rev;
		logic             eol;
	} cmd_t;

	// The back gives a bank back once its last entry has been read.
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [VALUE_W-1:0] data;
	} ram_wr_t;

endpackage

// File: sv/stream_group_reversal.sv
// ----------------------------------------------------------------------------
// stream_group_reversal
// Buffers a value stream into groups and emits each full group reversed.
// ----------------------------------------------------------------------------
// Values arrive one beat at a time with tlast marking the end of the list.
// Every group_size values leave again in reverse order; a partial group at
// the end of the list leaves in its original order. On the output tlast
// closes each burst and tuser flags the final value of the list. Two banks
// of MAX_GROUP entries in one RAM alternate between filling and playing out.
// A bank is free for new values in the cycle after the read of its last
// entry has been issued. When the output stalls, the input side stalls as
// soon as both banks hold groups not yet read. The output side is set by
// the single RAM read port, one result per cycle while the two-entry output
// buffer has room. A group closed while the back is idle passes through the
// command queue, cmd_q, the RAM read register and the output buffer first.
// The RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module stream_group_reversal (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sgr_pkg::GS_W-1:0]    cfg_data,   // group_size
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [sgr_pkg::VALUE_W-1:0] s_tdata,    // [31:0] value
	input  logic                        s_tlast,    // end_of_list
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [sgr_pkg::VALUE_W-1:0] m_tdata,    // [31:0] out_value
	output logic                        m_tlast,    // run_last
	output logic                        m_tuser     // [0] list_last
);

	sgr_pkg::cmd_t               push_cmd;
	sgr_pkg::cmd_t               head_cmd;
	sgr_pkg::release_t           rel;
	sgr_pkg::ram_wr_t            ram_wr;
	logic                        q_push;
	logic                        q_pop;
	logic                        q_full;
	logic                        q_valid;
	logic                        rd_en;
	logic [sgr_pkg::ADDR_W-1:0]  rd_addr;
	logic [sgr_pkg::VALUE_W-1:0] rd_data;

	sgr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd),
		.rel       (rel),
		.ram_wr    (ram_wr)
	);

	sgr_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (head_cmd)
	);

	sgr_ram #(
		.WIDTH (sgr_pkg::VALUE_W),
		.DEPTH (sgr_pkg::RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr.en),
		.wr_addr (ram_wr.addr),
		.wr_data (ram_wr.data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sgr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (head_cmd),
		.q_pop    (q_pop),
		.rel      (rel),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// File: sv/sgr_ram.sv
// ----------------------------------------------------------------------------
// sgr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sgr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/sgr_front.sv
// ----------------------------------------------------------------------------
// sgr_front
// Accepts input beats, stores them in the current bank and closes a group
// when it is full or the list ends.
// ----------------------------------------------------------------------------
module sgr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sgr_pkg::GS_W-1:0]    cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [sgr_pkg::VALUE_W-1:0] s_tdata,
	input  logic                        s_tlast,
	input  logic                        q_full,
	output logic                        q_push,
	output sgr_pkg::cmd_t               q_cmd,
	input  sgr_pkg::release_t           rel,
	output sgr_pkg::ram_wr_t            ram_wr
);

	logic [sgr_pkg::GS_W-1:0]  group_size_q;
	logic [sgr_pkg::CNT_W-1:0] fill_q;
	logic                      bank_q;
	logic [1:0]                busy_q;
	logic [1:0]                busy_d;
	logic [sgr_pkg::CNT_W-1:0] k_eff;
	logic [sgr_pkg::CNT_W-1:0] n_next;
	logic                      beat;
	logic                      full_group;
	logic                      flush;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= sgr_pkg::GS_W'(1);
		end else if (cfg_valid) begin
			group_size_q <= cfg_data;
		end
	end

	// A size of zero acts as one; sizes beyond the buffer saturate.
	always_comb begin
		if (group_size_q == '0) begin
			k_eff = sgr_pkg::CNT_W'(1);
		end else if (int'(group_size_q) > sgr_pkg::MAX_GROUP) begin
			k_eff = sgr_pkg::CNT_W'(sgr_pkg::MAX_GROUP);
		end else begin
			k_eff = sgr_pkg::CNT_W'(group_size_q);
		end
	end

	assign s_tready   = !busy_q[bank_q] && !q_full;
	assign beat       = s_tvalid && s_tready;
	assign n_next     = fill_q + sgr_pkg::CNT_W'(1);
	assign full_group = n_next >= k_eff;
	assign flush      = full_group || s_tlast;

	assign ram_wr.en   = beat;
	assign ram_wr.addr = {bank_q, fill_q[sgr_pkg::IDX_W-1:0]};
	assign ram_wr.data = s_tdata;

	assign q_push      = beat && flush;
	assign q_cmd.bank  = bank_q;
	assign q_cmd.count = n_next;
	assign q_cmd.rev   = full_group;
	assign q_cmd.eol   = s_tlast;

	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (q_push) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= busy_d;
			if (beat) begin
				if (flush) begin
					fill_q <= '0;
					bank_q <= !bank_q;
				end else begin
					fill_q <= n_next;
				end
			end
		end
	end

endmodule

// File: sv/sgr_cmd_queue.sv
// ----------------------------------------------------------------------------
// sgr_cmd_queue
// Two-entry queue of finished groups between the front and the back.
// ----------------------------------------------------------------------------
module sgr_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sgr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output sgr_pkg::cmd_t head
);

	sgr_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: sv/sgr_back.sv
// ----------------------------------------------------------------------------
// sgr_back
// Plays out one group at a time from its bank, reversed or in order, and
// holds results in a two-entry output buffer.
// ----------------------------------------------------------------------------
module sgr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  sgr_pkg::cmd_t               q_head,
	output logic                        q_pop,
	output sgr_pkg::release_t           rel,
	output logic                        rd_en,
	output logic [sgr_pkg::ADDR_W-1:0]  rd_addr,
	input  logic [sgr_pkg::VALUE_W-1:0] rd_data,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [sgr_pkg::VALUE_W-1:0] m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser
);

	sgr_pkg::cmd_t             cmd_q;
	logic                      active_q;
	logic [sgr_pkg::CNT_W-1:0] idx_q;
	logic                      rd_vld_s1;
	logic                      run_last_s1;
	logic                      list_last_s1;

	logic [sgr_pkg::VALUE_W-1:0] obuf_data_q [2];
	logic                        obuf_run_q  [2];
	logic                        obuf_list_q [2];
	logic                        owr_ptr_q;
	logic                        ord_ptr_q;
	logic [1:0]                  ocnt_q;

	logic [1:0]                occ;
	logic                      pop_out;
	logic                      issue;
	logic [sgr_pkg::CNT_W-1:0] last_idx;
	logic [sgr_pkg::CNT_W-1:0] src;
	logic                      is_last;

	assign pop_out = m_tvalid && m_tready;
	// Results already buffered plus the read in flight must leave room.
	assign occ     = ocnt_q + {1'b0, rd_vld_s1};
	assign issue   = active_q && ((occ < 2'd2) || ((occ == 2'd2) && pop_out));

	assign last_idx = cmd_q.count - sgr_pkg::CNT_W'(1);
	assign is_last  = idx_q == last_idx;
	assign src      = cmd_q.rev ? (last_idx - idx_q) : idx_q;

	assign rd_en   = issue;
	assign rd_addr = {cmd_q.bank, src[sgr_pkg::IDX_W-1:0]};

	assign rel.valid = issue && is_last;
	assign rel.bank  = cmd_q.bank;

	assign q_pop = q_valid && (!active_q || (issue && is_last));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (issue) begin
			run_last_s1  <= is_last;
			list_last_s1 <= is_last && cmd_q.eol;
		end
		if (rd_vld_s1) begin
			obuf_data_q[owr_ptr_q] <= rd_data;
			obuf_run_q[owr_ptr_q]  <= run_last_s1;
			obuf_list_q[owr_ptr_q] <= list_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			owr_ptr_q <= 1'b0;
			ord_ptr_q <= 1'b0;
			ocnt_q    <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (q_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (issue) begin
				if (is_last) begin
					active_q <= 1'b0;
				end
				idx_q <= idx_q + sgr_pkg::CNT_W'(1);
			end
			if (rd_vld_s1) begin
				owr_ptr_q <= !owr_ptr_q;
			end
			if (pop_out) begin
				ord_ptr_q <= !ord_ptr_q;
			end
			ocnt_q <= ocnt_q + {1'b0, rd_vld_s1} - {1'b0, pop_out};
		end
	end

	assign m_tvalid = ocnt_q != 2'd0;
	assign m_tdata  = obuf_data_q[ord_ptr_q];
	assign m_tlast  = obuf_run_q[ord_ptr_q];
	assign m_tuser  = obuf_list_q[ord_ptr_q];

endmodule

// File: sv/sgr_checker.sv
// ----------------------------------------------------------------------------
// sgr_checker
// Port-level checks for the stream group reversal block.
// ----------------------------------------------------------------------------
module sgr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [sgr_pkg::GS_W-1:0]    cfg_data,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [sgr_pkg::VALUE_W-1:0] m_tdata,
	input logic                        m_tlast,
	input logic                        m_tuser
);

	// Input beats taken but not yet delivered.
	logic [7:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {7'd0, in_beat} - {7'd0, out_beat};
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat withdrawn while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
			$stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("output payload changed while stalled");

	a_list_end_closes_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("end of list flagged inside a burst");

	a_no_invented_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pend_q != 8'd0)
		else $error("more results delivered than values accepted");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && !$isunknown(cfg_data))
		else $error("configuration write not taken");

endmodule

bind stream_group_reversal sgr_checker u_sgr_checker (.*);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stream group reversal block.
// ----------------------------------------------------------------------------
// A directed table opens the run. It covers the value extremes, the pass
// through at group sizes zero and one, the saturated group size, a full group
// closed by the end of the list, a group size lowered over buffered values,
// and a partial group at the end of a list. Random lists of random length
// follow. They run under several group sizes, with random gaps on both sides
// and one long output hold-off. Every output beat is compared with the
// oldest result that the bench's own group model expects.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int SEG_ITEMS   = 29;
	localparam int SEGMENTS    = 12;

	typedef struct packed {
		logic [sgr_pkg::VALUE_W-1:0] value;
		logic                        run_last;
		logic                        list_last;
	} result_t;

	typedef struct packed {
		logic                        is_cfg;
		logic [sgr_pkg::GS_W-1:0]    size;
		logic [sgr_pkg::VALUE_W-1:0] value;
		logic                        eol;
		logic                        typed;
		logic [sgr_pkg::VALUE_W-1:0] t_value;
		logic                        t_list;
	} plan_row_t;

	logic                        clk;
	logic                        arst_n    = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [sgr_pkg::GS_W-1:0]    cfg_data  = '0;
	logic                        s_tvalid  = 1'b0;
	logic                        s_tready;
	logic [sgr_pkg::VALUE_W-1:0] s_tdata   = '0;
	logic                        s_tlast   = 1'b0;
	logic                        m_tvalid;
	logic                        m_tready  = 1'b0;
	logic [sgr_pkg::VALUE_W-1:0] m_tdata;
	logic                        m_tlast;
	logic                        m_tuser;

	// Model state: held values, their count and the group size register.
	logic [sgr_pkg::VALUE_W-1:0] held_values [sgr_pkg::MAX_GROUP];
	int unsigned                 held_count     = 0;
	logic [sgr_pkg::GS_W-1:0]    group_size_reg = 5'd1;
	result_t                     expected_results [$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned tx_pct      = 26;
	int unsigned rx_pct      = 48;
	logic        rx_hold     = 1'b0;
	logic        pressure_go = 1'b0;

	plan_row_t directed_plan [30] = '{
		'{1'b0, 5'd0,  32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
		'{1'b0, 5'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
		'{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
		'{1'b0, 5'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
		// A group size of zero behaves as one.
		'{1'b1, 5'd0,  32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678, 1'b0},
		'{1'b0, 5'd0,  32'hEDCB_A987, 1'b1, 1'b1, 32'hEDCB_A987, 1'b1},
		// Saturated size: sixteen values, the last one also ends the list.
		'{1'b1, 5'd31, 32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_0001, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'hAAAA_5555, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h5555_AAAA, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_0004, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'hFFFF_FFFB, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_0006, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0F0F_0F0F, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'hF0F0_F0F0, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_0009, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_000A, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_000C, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_000D, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0,         1'b0},
		// Two values held at size four, then the size drops to two.
		'{1'b1, 5'd4,  32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_0011, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_0022, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b1, 5'd2,  32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_0033, 1'b0, 1'b0, 32'h0,         1'b0},
		'{1'b0, 5'd0,  32'h0000_0044, 1'b1, 1'b0, 32'h0,         1'b0}
	};

	logic [sgr_pkg::GS_W-1:0] segment_sizes [SEGMENTS] = '{
		5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd7, 5'd1, 5'd9, 5'd2, 5'd16, 5'd12, 5'd5
	};

	stream_group_reversal dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stores one value and, once a group is complete or the list ends, queues
	// the group: reversed when complete, in arrival order when cut short.
	function automatic void predict_groups(input logic [sgr_pkg::VALUE_W-1:0] v,
			input logic eol, input bit record);
		int unsigned k;
		int unsigned n;
		int unsigned src;
		result_t     r;
		if (group_size_reg == 0)
			k = 1;
		else if (group_size_reg > sgr_pkg::MAX_GROUP)
			k = sgr_pkg::MAX_GROUP;
		else
			k = group_size_reg;
		if (held_count >= sgr_pkg::MAX_GROUP)
			held_count = sgr_pkg::MAX_GROUP - 1;
		held_values[held_count] = v;
		held_count++;
		n = held_count;
		if (n >= k || eol) begin
			if (record) begin
				for (int unsigned i = 0; i < n; i++) begin
					src = (n >= k) ? n - 1 - i : i;
					r.value     = held_values[src];
					r.run_last  = (i + 1 == n);
					r.list_last = (i + 1 == n) && eol;
					expected_results.push_back(r);
				end
			end
			held_count = 0;
		end
	endfunction

	task automatic send_value(input logic [sgr_pkg::VALUE_W-1:0] v, input logic eol,
			input bit typed, input logic [sgr_pkg::VALUE_W-1:0] t_value,
			input logic t_list);
		result_t r;
		if ($urandom_range(99) < tx_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= eol;
		do @(posedge clk); while (!s_tready);
		if (typed) begin
			r.value     = t_value;
			r.run_last  = 1'b1;
			r.list_last = t_list;
			expected_results.push_back(r);
		end
		predict_groups(v, eol, !typed);
	endtask

	task automatic drain_results;
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_group_size(input logic [sgr_pkg::GS_W-1:0] size);
		cfg_valid <= 1'b1;
		cfg_data  <= size;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		group_size_reg = size;
	endtask

	function automatic logic [sgr_pkg::VALUE_W-1:0] random_value;
		case ($urandom_range(15))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Output side: checks each beat and draws the next tready.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected beat, actual value %h tlast %b tuser %b",
					$time, m_tdata, m_tlast, m_tuser);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata !== want.value) begin
					error_count++;
					$display("%0t: value expected %h actual %h", $time, want.value, m_tdata);
				end
				if (m_tlast !== want.run_last) begin
					error_count++;
					$display("%0t: tlast expected %b actual %b", $time, want.run_last, m_tlast);
				end
				if (m_tuser !== want.list_last) begin
					error_count++;
					$display("%0t: tuser expected %b actual %b", $time, want.list_last, m_tuser);
				end
			end
		end
		if (rx_hold)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= rx_pct);
	end

	// Long output hold-off so the banks fill and the input side stalls.
	initial begin
		wait (pressure_go);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		int unsigned list_left;
		int unsigned k;
		logic        eol;
		list_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[r]) begin
			if (directed_plan[r].is_cfg) begin
				drain_results();
				write_group_size(directed_plan[r].size);
			end else begin
				send_value(directed_plan[r].value, directed_plan[r].eol,
					directed_plan[r].typed, directed_plan[r].t_value,
					directed_plan[r].t_list);
			end
		end

		// Lists run across segment borders, so some sizes change over held values.
		for (int s = 0; s < SEGMENTS; s++) begin
			drain_results();
			if (s == SEGMENTS / 3) begin
				tx_pct <= 48;
				rx_pct <= 26;
			end else if (s == 2 * SEGMENTS / 3) begin
				tx_pct <= 0;
				rx_pct <= 0;
			end
			write_group_size(segment_sizes[s]);
			if (s == 2 * SEGMENTS / 3)
				pressure_go <= 1'b1;
			k = (segment_sizes[s] == 0) ? 1 :
				(segment_sizes[s] > sgr_pkg::MAX_GROUP) ? sgr_pkg::MAX_GROUP :
				segment_sizes[s];
			for (int i = 0; i < SEG_ITEMS; i++) begin
				if (list_left == 0)
					list_left = ($urandom_range(7) == 0) ? 1 : $urandom_range(1, 2 * k + 3);
				eol = (list_left == 1);
				list_left--;
				send_value(random_value(), eol, 1'b0, '0, 1'b0);
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
